// File: design/isort_pkg.sv
// isort_pkg: shared constants, types and the store access request for the insertion sorter
// no dependencies; compiled first
package isort_pkg;

  // store capacity and derived widths
  localparam int DEPTH  = 32;
  localparam int DATA_W = 32;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  // one cycle of store traffic: one write port, one read port
  typedef struct packed {
    logic  we;
    addr_t waddr;
    data_t wdata;
    logic  re;
    addr_t raddr;
  } mem_req_t;

endpackage

// File: design/isort_if.sv
// isort_in_if / isort_out_if: valid/ready channels for input values and sorted results
// depends on isort_pkg
interface isort_in_if;
  import isort_pkg::*;

  logic  valid;
  logic  ready;
  data_t value;
  logic  last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface isort_out_if;
  import isort_pkg::*;

  logic  valid;
  logic  ready;
  data_t sorted_value;
  logic  last_out;
  logic  overflowed;

  modport source (output valid, output sorted_value, output last_out, output overflowed,
                  input ready);
  modport sink   (input valid, input sorted_value, input last_out, input overflowed,
                  output ready);
endinterface

// File: design/isort_ram.sv
// isort_ram: simple dual-port synchronous ram, one write and one registered read per cycle
// generic; no package dependency
module isort_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 5
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/isort_ctrl.sv
// isort_ctrl: sequencer for insertion (read, compare, shift up) and for draining the store
// depends on isort_pkg and the channel interfaces in isort_if.sv
module isort_ctrl (
  input  logic                clk,
  input  logic                rst,
  isort_in_if.sink            items,
  isort_out_if.source         results,
  output isort_pkg::mem_req_t req,
  input  isort_pkg::data_t    rd_data
);
  import isort_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_PLACE,
    S_EMIT,
    S_LOAD,
    S_WAIT
  } state_t;

  state_t state, state_next;
  addr_t  pos, pos_next;
  addr_t  k, k_next;
  cnt_t   fill_count, fill_count_next;
  logic   drop_flag, drop_flag_next;
  data_t  val, val_next;
  logic   last_hold, last_hold_next;
  logic   out_valid, out_valid_next;
  data_t  out_value, out_value_next;
  logic   out_last, out_last_next;
  logic   out_ovf, out_ovf_next;

  // port drive
  assign items.ready          = (state == S_IDLE);
  assign results.valid        = out_valid;
  assign results.sorted_value = out_value;
  assign results.last_out     = out_last;
  assign results.overflowed   = out_ovf;

  // next state and store traffic
  always_comb begin
    state_next      = state;
    pos_next        = pos;
    k_next          = k;
    fill_count_next = fill_count;
    drop_flag_next  = drop_flag;
    val_next        = val;
    last_hold_next  = last_hold;
    out_valid_next  = out_valid;
    out_value_next  = out_value;
    out_last_next   = out_last;
    out_ovf_next    = out_ovf;
    req             = '0;

    unique case (state)
      S_IDLE: begin
        if (items.valid) begin
          val_next       = items.value;
          last_hold_next = items.last;
          k_next         = '0;
          if (fill_count == CNT_W'(DEPTH)) begin
            // store full: drop the value
            drop_flag_next = 1'b1;
            state_next     = items.last ? S_EMIT : S_IDLE;
          end else if (fill_count == '0) begin
            req.we          = 1'b1;
            req.waddr       = '0;
            req.wdata       = items.value;
            fill_count_next = fill_count + CNT_W'(1);
            state_next      = items.last ? S_EMIT : S_IDLE;
          end else begin
            // start the walk down from the top entry
            pos_next   = fill_count[ADDR_W-1:0];
            req.re     = 1'b1;
            req.raddr  = ADDR_W'(fill_count - CNT_W'(1));
            state_next = S_CMP;
          end
        end
      end

      S_CMP: begin
        if ($signed(rd_data) > $signed(val)) begin
          // move the larger entry up one place
          req.we    = 1'b1;
          req.waddr = pos;
          req.wdata = rd_data;
          pos_next  = pos - ADDR_W'(1);
          if (pos == ADDR_W'(1)) begin
            state_next = S_PLACE;
          end else begin
            req.re    = 1'b1;
            req.raddr = pos - ADDR_W'(2);
          end
        end else begin
          req.we          = 1'b1;
          req.waddr       = pos;
          req.wdata       = val;
          fill_count_next = fill_count + CNT_W'(1);
          state_next      = last_hold ? S_EMIT : S_IDLE;
        end
      end

      S_PLACE: begin
        req.we          = 1'b1;
        req.waddr       = '0;
        req.wdata       = val;
        fill_count_next = fill_count + CNT_W'(1);
        state_next      = last_hold ? S_EMIT : S_IDLE;
      end

      S_EMIT: begin
        req.re     = 1'b1;
        req.raddr  = k;
        state_next = S_LOAD;
      end

      S_LOAD: begin
        out_valid_next = 1'b1;
        out_value_next = rd_data;
        out_last_next  = ((CNT_W'(k) + CNT_W'(1)) == fill_count);
        out_ovf_next   = drop_flag;
        state_next     = S_WAIT;
      end

      S_WAIT: begin
        if (results.ready) begin
          out_valid_next = 1'b0;
          if (out_last) begin
            // set done, the store empties
            fill_count_next = '0;
            drop_flag_next  = 1'b0;
            state_next      = S_IDLE;
          end else begin
            k_next     = k + ADDR_W'(1);
            req.re     = 1'b1;
            req.raddr  = k + ADDR_W'(1);
            state_next = S_LOAD;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      drop_flag  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
      drop_flag  <= drop_flag_next;
      out_valid  <= out_valid_next;
    end
    pos       <= pos_next;
    k         <= k_next;
    val       <= val_next;
    last_hold <= last_hold_next;
    out_value <= out_value_next;
    out_last  <= out_last_next;
    out_ovf   <= out_ovf_next;
  end

  // no input beat while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    items.ready |-> !out_valid)
    else $error("input taken while a result is pending");

  // fill count never passes capacity
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(DEPTH))
    else $error("fill count beyond capacity");

  // the walk never compares below the bottom entry
  a_pos_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (pos != '0))
    else $error("compare at position zero");

  // final beat of a set empties the store
  a_set_clears: assert property (@(posedge clk) disable iff (rst)
    (out_valid && results.ready && out_last) |=> (fill_count == '0 && !drop_flag))
    else $error("store not emptied after final beat");

endmodule

// File: design/insertion_sorter.sv
// insertion_sorter: insertion sort of signed 32-bit values into a ram-held sorted store
// insertion: the walk starts at the top entry and moves each larger entry up a place in S_CMP;
//   the value is written in S_CMP or S_PLACE, straight into an empty store, or dropped when full
// throughput: one item per insertion walk, set by the single read/write port pair of the store
// output: result beats come registered from the store read port; no item is taken while draining
// reset: sync, active high; clears control, fill count and drop flag; store is not cleared
module insertion_sorter (
  input  logic        clk,
  input  logic        rst,
  isort_in_if.sink    items,
  isort_out_if.source results
);
  import isort_pkg::*;

  mem_req_t req;
  data_t    rd_data;

  // insertion and drain sequencer
  isort_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .results (results),
    .req     (req),
    .rd_data (rd_data)
  );

  // sorted store
  isort_ram #(
    .DATA_W (DATA_W),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (req.we),
    .waddr (req.waddr),
    .wdata (req.wdata),
    .re    (req.re),
    .raddr (req.raddr),
    .rdata (rd_data)
  );

endmodule
